// File: hw/rtl/wsc_pkg.sv
// ----------------------------------------------------------------------------
// wsc_pkg
// Shared types and constants for the waypoint steering control unit.
// ----------------------------------------------------------------------------
package wsc_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int ZW = 28;  // CORDIC angle accumulator, 24 fraction bits

    localparam logic signed [15:0] ANG_PI      = 16'sd12868;
    localparam logic signed [15:0] ANG_HALF_PI = 16'sd6434;
    localparam logic signed [15:0] ANG_TWO_PI  = 16'sd25736;
    localparam logic signed [ZW-1:0] Z_HALF_PI = 28'sd26353589;

    localparam logic [2:0] REG_TOL   = 3'd0;
    localparam logic [2:0] REG_DGAIN = 3'd1;
    localparam logic [2:0] REG_FLIM  = 3'd2;
    localparam logic [2:0] REG_RLIM  = 3'd3;
    localparam logic [2:0] REG_FTURN = 3'd4;
    localparam logic [2:0] REG_RTURN = 3'd5;
    localparam logic [2:0] REG_WIN   = 3'd6;

    typedef struct packed {
        logic [7:0]  tol;
        logic [3:0]  dgain;
        logic [11:0] flim;
        logic [11:0] rlim;
        logic [3:0]  fturn;
        logic [3:0]  rturn;
        logic [13:0] win;
    } cfg_t;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] i);
        logic signed [ZW-1:0] r;
        case (i)
            5'd0: r = 28'sd13176795;
            5'd1: r = 28'sd7778716;
            5'd2: r = 28'sd4110060;
            5'd3: r = 28'sd2086331;
            5'd4: r = 28'sd1047214;
            5'd5: r = 28'sd524117;
            5'd6: r = 28'sd262123;
            5'd7: r = 28'sd131069;
            default: r = (i < 5'd24) ? (28'sd1 <<< (5'd24 - i)) : 28'sd0;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/waypoint_steering_control_unit.sv
// ----------------------------------------------------------------------------
// waypoint_steering_control_unit
// Go-to-goal proportional controller: pose and goal in, velocity word out.
// ----------------------------------------------------------------------------
//  channel | dir | fields (low bit up)
//  s_axis  | in  | goal_x16 goal_y16 pose_x16 pose_y16 pose_theta15
//  m_axis  | out | linear_speed13 angular_speed18, tuser: arrived reversing
//  cfg     | in  | cfg_we / cfg_index / cfg_wdata
// One word: accept, square root (start, 17 bit steps, done), CORDIC, then fold,
// multiply and output states. On arrival the word goes straight from the square
// root to output, and a zero displacement skips the CORDIC. With a ready
// receiver the next word is taken once the result has been handed over.
// Not ready while a word is in flight or a result waits in the output register.
// Reset is synchronous, active low; reverse mode comes out armed.
// ----------------------------------------------------------------------------
module waypoint_steering_control_unit
    import wsc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // goal_x, goal_y, pose_x, pose_y, pose_theta, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // linear_speed, angular_speed, pad
    output logic [1:0]  m_tuser,  // arrived, reversing
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [13:0] cfg_wdata
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_SQRT = 6'b000010, S_CORD = 6'b000100,
        S_ERR  = 6'b001000, S_MUL  = 6'b010000, S_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    cfg_t cfg_reg;
    logic armed_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [14:0] th_reg;
    logic [16:0] dist_reg;
    logic signed [15:0] e_reg, dal_reg;
    logic behind_reg;
    logic [12:0] lin_reg;
    logic [17:0] ang_reg;
    logic arr_reg, rev_reg;

    logic sq_done, co_done;
    logic [16:0] root;
    logic signed [15:0] alpha;
    logic [33:0] rad;
    logic sq_start, co_start;
    logic sq_go;

    assign rad = 34'(dx_reg) * 34'(dx_reg) + 34'(dy_reg) * 34'(dy_reg);
    assign sq_start = (state_reg == S_IDLE) && s_tvalid && !m_tvalid;
    assign co_start = (state_reg == S_SQRT) && sq_done && (root >= {9'd0, cfg_reg.tol});

    wsc_isqrt u_sqrt (.aclk, .aresetn, .start(state_reg == S_SQRT && !sq_done && !sq_go),
        .radicand(rad), .done(sq_done), .root);
    always_ff @(posedge aclk) sq_go <= (state_reg == S_SQRT);

    wsc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (.aclk, .aresetn, .start(co_start),
        .dx(dx_reg), .dy(dy_reg), .done(co_done), .angle(alpha));

    // wrap helper: inputs stay within a couple of turns
    function automatic logic signed [17:0] wrap1(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (r > 18'(ANG_PI)) r = r - 18'(ANG_TWO_PI);
        if (r > 18'(ANG_PI)) r = r - 18'(ANG_TWO_PI);
        if (r <= -18'(ANG_PI)) r = r + 18'(ANG_TWO_PI);
        if (r <= -18'(ANG_PI)) r = r + 18'(ANG_TWO_PI);
        return r;
    endfunction

    logic signed [17:0] e_w, b_w;
    logic signed [16:0] b_abs;
    logic [20:0] spd;
    logic [11:0] lim, spd_sat;
    logic signed [21:0] angp;
    logic zero_disp;
    assign zero_disp = (dx_reg == 0) && (dy_reg == 0);
    assign e_w = wrap1(18'(zero_disp ? 16'sd0 : alpha) - 18'(th_reg));
    assign b_w = wrap1(18'(e_reg) - 18'(ANG_PI));
    assign b_abs = b_w[17] ? 17'(-b_w) : 17'(b_w);
    assign spd = 21'(cfg_reg.dgain) * 21'(dist_reg);
    assign lim = behind_reg ? cfg_reg.rlim : cfg_reg.flim;
    assign spd_sat = (spd > 21'(lim)) ? lim : spd[11:0];
    assign angp = behind_reg ? -(22'($signed({1'b0, cfg_reg.rturn})) * 22'(dal_reg))
                             :  22'($signed({1'b0, cfg_reg.fturn})) * 22'(dal_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            armed_reg <= 1'b1;
            m_tvalid  <= 1'b0;
            cfg_reg   <= '{tol: 8'd3, dgain: 4'd4, flim: 12'd1536, rlim: 12'd2048,
                           fturn: 4'd6, rturn: 4'd4, win: 14'd6144};
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TOL:   cfg_reg.tol   <= cfg_wdata[7:0];
                    REG_DGAIN: cfg_reg.dgain <= cfg_wdata[3:0];
                    REG_FLIM:  cfg_reg.flim  <= cfg_wdata[11:0];
                    REG_RLIM:  cfg_reg.rlim  <= cfg_wdata[11:0];
                    REG_FTURN: cfg_reg.fturn <= cfg_wdata[3:0];
                    REG_RTURN: cfg_reg.rturn <= cfg_wdata[3:0];
                    REG_WIN:   cfg_reg.win   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (sq_start) begin
                    dx_reg <= 17'($signed(s_tdata[15:0])) - 17'($signed(s_tdata[47:32]));
                    dy_reg <= 17'($signed(s_tdata[31:16])) - 17'($signed(s_tdata[63:48]));
                    th_reg <= s_tdata[78:64];
                    state_reg <= S_SQRT;
                end
                S_SQRT: if (sq_done) begin
                    dist_reg <= root;
                    if (root < {9'd0, cfg_reg.tol}) begin
                        lin_reg <= '0; ang_reg <= '0; arr_reg <= 1'b1; rev_reg <= 1'b0;
                        armed_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else if (zero_disp) begin
                        state_reg <= S_ERR;
                        e_reg <= e_w[15:0];
                    end else state_reg <= S_CORD;
                end
                S_CORD: if (co_done) begin
                    e_reg <= e_w[15:0];
                    state_reg <= S_ERR;
                end
                S_ERR: begin
                    if (e_reg > ANG_HALF_PI) dal_reg <= ANG_PI - e_reg;
                    else if (e_reg < -ANG_HALF_PI) dal_reg <= -ANG_PI - e_reg;
                    else dal_reg <= e_reg;
                    behind_reg <= armed_reg && (b_abs <= {3'd0, cfg_reg.win});
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    lin_reg <= behind_reg ? -{1'b0, spd_sat} : {1'b0, spd_sat};
                    ang_reg <= angp[17:0];
                    arr_reg <= 1'b0;
                    rev_reg <= behind_reg;
                    if (!behind_reg) armed_reg <= 1'b0;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_tvalid  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE) && !m_tvalid;
    assign m_tdata  = {1'b0, ang_reg, lin_reg};
    assign m_tuser  = {rev_reg, arr_reg};
endmodule

// File: hw/rtl/wsc_isqrt.sv
// ----------------------------------------------------------------------------
// wsc_isqrt
// Bit-pair restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module wsc_isqrt
    import wsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [33:0] radicand,
    output logic        done,
    output logic [16:0] root
);
    logic [33:0] rem_reg;
    logic [33:0] val_reg;
    logic [16:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] trial;
    logic [35:0] rem_sh;

    always_comb begin
        rem_sh = {rem_reg, val_reg[33:32]};
        trial  = rem_sh - {17'd0, root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd17;
                rem_reg  <= '0;
                root_reg <= '0;
                val_reg  <= radicand;
            end else if (busy_reg) begin
                val_reg <= {val_reg[31:0], 2'b00};
                if (!trial[35]) begin
                    rem_reg  <= trial[33:0];
                    root_reg <= {root_reg[15:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh[33:0];
                    root_reg <= {root_reg[15:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// File: hw/rtl/wsc_cordic.sv
// ----------------------------------------------------------------------------
// wsc_cordic
// Vectoring CORDIC, one micro-rotation per cycle; gives atan2 in Q4.12.
// ----------------------------------------------------------------------------
module wsc_cordic
    import wsc_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [16:0] dx,
    input  logic signed [16:0] dy,
    output logic               done,
    output logic signed [15:0] angle
);
    localparam int NS = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

    logic signed [27:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0] i_reg;
    logic busy_reg, done_reg;
    logic signed [27:0] xs, ys, x0, y0;
    logic signed [ZW-1:0] zr;

    always_comb begin
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        x0 = {{3{dx[16]}}, dx, 8'd0};
        y0 = {{3{dy[16]}}, dy, 8'd0};
        zr = z_reg + ZW'(2048);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                if (dx < 0 && dy >= 0) begin
                    x_reg <= y0; y_reg <= -x0; z_reg <= Z_HALF_PI;
                end else if (dx < 0) begin
                    x_reg <= -y0; y_reg <= x0; z_reg <= -Z_HALF_PI;
                end else begin
                    x_reg <= x0; y_reg <= y0; z_reg <= '0;
                end
            end else if (busy_reg) begin
                if (y_reg > 0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_entry(i_reg);
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_entry(i_reg);
                end
                i_reg <= i_reg + 5'd1;
                if (i_reg == 5'(NS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done  = done_reg;
    assign angle = zr[27:12];
endmodule

// File: hw/rtl/wsc_checker.sv
// ----------------------------------------------------------------------------
// wsc_checker
// Port-level checks on the steering control unit.
// ----------------------------------------------------------------------------
module wsc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    // one word in flight: no accept while a result is held
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept with result pending");
    // arrival gives a zero command and no reverse
    a_arr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0 && !m_tuser[1]))
        else $error("arrival word not zero");
    // no result right after accept
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid) else $error("result too early");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");
endmodule

bind waypoint_steering_control_unit wsc_checker u_wsc_checker (.*);
